// ===== sv/tft_pkg.sv =====
// Shared types and constants for the touch frame tracker.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package tft_pkg;

    localparam int MAX_SLOTS = 5;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = 4;

    localparam logic [7:0] FRAME_MARKER = 8'hEE;
    localparam logic [7:0] CODE_MASK    = 8'h1F;

    localparam logic [4:0] HDR_NOTIFY = 5'd16;
    localparam logic [4:0] HDR_ENABLE = 5'd15;
    localparam logic [4:0] SUB_TOUCH  = 5'd0;
    localparam logic [4:0] SUB_BOOT   = 5'd3;
    localparam logic [4:0] SUB_ENABLE = 5'd5;

    localparam logic [7:0] POS_HEADER  = 8'd0;
    localparam logic [7:0] POS_SUBTYPE = 8'd6;
    localparam logic [7:0] POS_COUNT   = 8'd7;
    localparam logic [7:0] POS_RECORDS = 8'd10;
    localparam logic [7:0] MIN_LENGTH  = 8'd7;
    localparam logic [7:0] RECORD_LEN  = 8'd11;

    localparam logic [3:0] OFF_ID     = 4'd0;
    localparam logic [3:0] OFF_EVENT  = 4'd1;
    localparam logic [3:0] OFF_X_HI   = 4'd2;
    localparam logic [3:0] OFF_X_LO   = 4'd3;
    localparam logic [3:0] OFF_Y_HI   = 4'd4;
    localparam logic [3:0] OFF_Y_LO   = 4'd5;
    localparam logic [3:0] OFF_W_HI   = 4'd6;
    localparam logic [3:0] OFF_W_LO   = 4'd7;
    localparam logic [3:0] OFF_LAST   = 4'd10;

    localparam logic [7:0] EVENT_DOWN = 8'd0;
    localparam logic [7:0] EVENT_UP   = 8'd2;
    localparam logic [7:0] HOLD_MAX   = 8'hFF;

    localparam logic [2:0] KIND_TOUCH  = 3'd0;
    localparam logic [2:0] KIND_SYNC   = 3'd1;
    localparam logic [2:0] KIND_BOOT   = 3'd2;
    localparam logic [2:0] KIND_ENABLE = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_LEN,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic [7:0]         id;
        logic [7:0]         event_code;
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        width;
        logic signed [16:0] vel_x;
        logic signed [16:0] vel_y;
        logic [7:0]         hold;
    } t_slot;

    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         slot;
        logic [7:0]         touch_id;
        logic               tip;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        touch_width;
        logic signed [16:0] velocity_x;
        logic signed [16:0] velocity_y;
        logic [7:0]         hold_count;
        logic [2:0]         num_touches;
        logic               last_of_run;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/tft_if.sv =====
// Stream interfaces for the touch frame tracker: byte input and result output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tft_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface tft_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [2:0]         slot;
    logic [7:0]         touch_id;
    logic               tip;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [15:0]        touch_width;
    logic signed [16:0] velocity_x;
    logic signed [16:0] velocity_y;
    logic [7:0]         hold_count;
    logic [2:0]         num_touches;
    logic               last_of_run;

    modport source (
        output valid, output kind, output slot, output touch_id, output tip,
        output pos_x, output pos_y, output touch_width, output velocity_x,
        output velocity_y, output hold_count, output num_touches,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input slot, input touch_id, input tip,
        input pos_x, input pos_y, input touch_width, input velocity_x,
        input velocity_y, input hold_count, input num_touches,
        input last_of_run, output ready
    );
endinterface

`default_nettype wire

// ===== sv/touch_frame_tracker.sv =====
// Touch frame tracker: frame parser, slot tracker and result queue.
// Depends on tft_pkg and the interfaces in tft_if.sv.
//
//   port        | dir | transfer moves
//   ------------+-----+------------------------------------------
//   i_in        | in  | one frame byte
//   o_out       | out | one result (report, sync, status, error)
//   i_cfg_we/.. | in  | x_offset write, taken on any edge with we high
//
// One byte a cycle: a transfer lands in the input register, and the next
// cycle the parser and slot logic update state and push up to two results
// into an eight-entry result queue. The queue sets the input rate: i_in.ready
// drops only while the queue lacks room for the byte in flight and one more.
// Synchronous active-low reset returns the parser to marker hunt, clears all
// slots and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module touch_frame_tracker
    import tft_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [15:0] i_cfg_wdata,
    tft_byte_if.sink   i_in,
    tft_result_if.source o_out
);

    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // parser state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_pos, n_pos;
    logic [4:0]  r_header, n_header;
    logic [4:0]  r_subtype, n_subtype;
    logic [CNT_W-1:0] r_touches, n_touches;
    logic [CNT_W-1:0] r_prev, n_prev;
    logic [7:0]  r_high, n_high;
    logic [4:0]  r_rec_k, n_rec_k;
    logic [3:0]  r_rec_off, n_rec_off;
    logic [15:0] r_x_offset;

    t_slot       r_slot [MAX_SLOTS];
    t_slot       n_slot [MAX_SLOTS];

    // result queue
    t_result     r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic        in_fire, out_fire;
    logic [7:0]  b;
    logic        in_body, touch_frame, end_of_frame, rec_act;
    logic [SLOT_W-1:0] k_idx;
    logic [CNT_W-1:0]  count_cap;
    logic [15:0] v_word, x_new;
    t_slot       cur, src, upd;
    logic        rep_valid, tail_valid;
    t_result     rep, tail, res0, res1;
    logic [1:0]  n_res;
    logic [QCNT_W:0] q_need;

    function automatic logic signed [16:0] smooth(input logic signed [16:0] old,
                                                  input logic signed [17:0] diff);
        logic signed [20:0] o_ext;
        logic signed [20:0] s;
        logic signed [20:0] t;
        o_ext = 21'(old);
        s = (o_ext <<< 3) - o_ext + 21'(diff);
        // truncate toward zero
        t = s[20] ? (s + 21'sd7) : s;
        t = t >>> 3;
        return t[16:0];
    endfunction

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign b        = r_in_byte;

    // room for the byte in flight and for this one, two results each
    assign q_need     = {1'b0, r_count} + (r_in_valid ? (QCNT_W + 1)'(2) : '0);
    assign i_in.ready = (q_need <= (QCNT_W + 1)'(QDEPTH - 2));

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (r_in_valid) begin
            case (r_phase)
                PH_MARK: begin
                    if (b == FRAME_MARKER) n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_phase = (b == 8'd0) ? PH_MARK : PH_BODY;
                end
                PH_BODY: begin
                    if (end_of_frame) n_phase = PH_MARK;
                end
                default: n_phase = PH_MARK;
            endcase
        end
    end

    // datapath and results
    always_comb begin
        n_length  = r_length;
        n_pos     = r_pos;
        n_header  = r_header;
        n_subtype = r_subtype;
        n_touches = r_touches;
        n_prev    = r_prev;
        n_high    = r_high;
        n_rec_k   = r_rec_k;
        n_rec_off = r_rec_off;
        n_slot    = r_slot;
        rep_valid  = 1'b0;
        tail_valid = 1'b0;
        rep  = '0;
        tail = '0;

        in_body = r_in_valid && (r_phase == PH_BODY);
        if (r_pos == POS_HEADER)  n_header  = 5'(b & CODE_MASK);
        if (r_pos == POS_SUBTYPE) n_subtype = 5'(b & CODE_MASK);
        touch_frame = (n_header == HDR_NOTIFY) && (n_subtype == SUB_TOUCH)
                      && (r_pos >= POS_SUBTYPE);

        count_cap = '0;
        for (int i = 1; i <= MAX_SLOTS; i++) begin
            if (b >= 8'(11 * i)) count_cap = CNT_W'(i);
        end
        if (touch_frame && (r_pos == POS_COUNT)) n_touches = count_cap;

        end_of_frame = ({1'b0, r_pos} + 9'd1) >= {1'b0, r_length};
        rec_act = in_body && touch_frame && (r_pos >= POS_RECORDS)
                  && ({1'b0, r_rec_k} < 6'(n_touches));
        k_idx = r_rec_k[SLOT_W-1:0];

        cur    = r_slot[k_idx];
        v_word = {r_high, b};
        x_new  = (v_word > r_x_offset) ? (v_word - r_x_offset) : 16'd0;

        // id match: take over the last later slot that carries this id
        src = cur;
        if (b != cur.id) begin
            for (int j = 0; j < MAX_SLOTS; j++) begin
                if ((SLOT_W'(j) > k_idx) && (CNT_W'(j) < r_prev) && (r_slot[j].id == b))
                    src = r_slot[j];
            end
        end

        upd = cur;
        case (r_rec_off)
            OFF_ID: begin
                upd    = src;
                upd.id = b;
            end
            OFF_EVENT: upd.event_code = b;
            OFF_X_HI, OFF_Y_HI, OFF_W_HI: begin
                if (rec_act) n_high = b;
            end
            OFF_X_LO: begin
                upd.vel_x = smooth(cur.vel_x, $signed({2'b00, x_new}) - $signed({2'b00, cur.x}));
                upd.x     = x_new;
            end
            OFF_Y_LO: begin
                upd.vel_y = smooth(cur.vel_y,
                                   $signed({2'b00, v_word}) - $signed({2'b00, cur.y}));
                upd.y     = v_word;
            end
            OFF_W_LO: begin
                upd.width = 16'((({3'b000, cur.width} << 3) - {3'b000, cur.width}
                                 + {3'b000, v_word}) >> 3);
                if (cur.event_code == EVENT_DOWN) begin
                    upd.hold  = 8'd1;
                    upd.vel_x = '0;
                    upd.vel_y = '0;
                end else if (cur.hold != HOLD_MAX) begin
                    upd.hold = cur.hold + 8'd1;
                end
            end
            default: ;
        endcase
        if (rec_act) begin
            n_slot[k_idx] = upd;
            if (r_rec_off == OFF_W_LO) begin
                rep_valid        = 1'b1;
                rep.kind         = KIND_TOUCH;
                rep.slot         = 3'(r_rec_k);
                rep.touch_id     = upd.id;
                rep.tip          = (upd.event_code != EVENT_UP);
                rep.pos_x        = upd.x;
                rep.pos_y        = upd.y;
                rep.touch_width  = upd.width;
                rep.velocity_x   = upd.vel_x;
                rep.velocity_y   = upd.vel_y;
                rep.hold_count   = upd.hold;
            end
        end

        if (r_in_valid) begin
            case (r_phase)
                PH_MARK: begin
                    n_header  = r_header;
                    n_subtype = r_subtype;
                    n_touches = r_touches;
                    if (b != FRAME_MARKER) begin
                        tail_valid = 1'b1;
                        tail.kind  = KIND_ERROR;
                    end
                end
                PH_LEN: begin
                    n_header  = '0;
                    n_subtype = '0;
                    n_touches = '0;
                    if (b != 8'd0) begin
                        n_length  = b;
                        n_pos     = '0;
                        n_rec_k   = '0;
                        n_rec_off = '0;
                    end else begin
                        n_header  = r_header;
                        n_subtype = r_subtype;
                        n_touches = r_touches;
                    end
                end
                PH_BODY: begin
                    n_pos = r_pos + 8'd1;
                    if (r_pos >= POS_RECORDS) begin
                        if (r_rec_off == OFF_LAST) begin
                            n_rec_off = '0;
                            n_rec_k   = r_rec_k + 5'd1;
                        end else begin
                            n_rec_off = r_rec_off + 4'd1;
                        end
                    end
                    if (end_of_frame && (r_length >= MIN_LENGTH)) begin
                        if (n_header == HDR_NOTIFY && n_subtype == SUB_TOUCH) begin
                            tail_valid       = 1'b1;
                            tail.kind        = KIND_SYNC;
                            tail.num_touches = 3'(n_touches);
                            n_prev           = n_touches;
                        end else if (n_header == HDR_NOTIFY && n_subtype == SUB_BOOT) begin
                            tail_valid = 1'b1;
                            tail.kind  = KIND_BOOT;
                        end else if (n_header == HDR_ENABLE && n_subtype == SUB_ENABLE) begin
                            tail_valid = 1'b1;
                            tail.kind  = KIND_ENABLE;
                        end
                    end
                end
                default: begin
                    n_header  = r_header;
                    n_subtype = r_subtype;
                    n_touches = r_touches;
                end
            endcase
        end else begin
            n_header  = r_header;
            n_subtype = r_subtype;
            n_touches = r_touches;
        end

        // order: report first, then the frame-level result
        n_res = {1'b0, rep_valid} + {1'b0, tail_valid};
        res0  = rep_valid ? rep : tail;
        res1  = tail;
        res0.last_of_run = (n_res == 2'd1);
        res1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_MARK;
            r_length   <= '0;
            r_pos      <= '0;
            r_header   <= '0;
            r_subtype  <= '0;
            r_touches  <= '0;
            r_prev     <= '0;
            r_high     <= '0;
            r_rec_k    <= '0;
            r_rec_off  <= '0;
            r_x_offset <= '0;
            for (int i = 0; i < MAX_SLOTS; i++) r_slot[i] <= '0;
        end else begin
            r_in_valid <= in_fire;
            r_phase    <= n_phase;
            r_length   <= n_length;
            r_pos      <= n_pos;
            r_header   <= n_header;
            r_subtype  <= n_subtype;
            r_touches  <= n_touches;
            r_prev     <= n_prev;
            r_high     <= n_high;
            r_rec_k    <= n_rec_k;
            r_rec_off  <= n_rec_off;
            r_slot     <= n_slot;
            if (i_cfg_we) r_x_offset <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_in_byte <= i_in.data_byte;
    end

    // result queue: push up to two, pop one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(n_res);
            if (out_fire) r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count  <= r_count + QCNT_W'(n_res) - (out_fire ? QCNT_W'(1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res != 2'd0) r_queue[r_wr_ptr] <= res0;
        if (n_res == 2'd2) r_queue[r_wr_ptr + QPTR_W'(1)] <= res1;
    end

    assign o_out.valid       = (r_count != '0);
    assign o_out.kind        = r_queue[r_rd_ptr].kind;
    assign o_out.slot        = r_queue[r_rd_ptr].slot;
    assign o_out.touch_id    = r_queue[r_rd_ptr].touch_id;
    assign o_out.tip         = r_queue[r_rd_ptr].tip;
    assign o_out.pos_x       = r_queue[r_rd_ptr].pos_x;
    assign o_out.pos_y       = r_queue[r_rd_ptr].pos_y;
    assign o_out.touch_width = r_queue[r_rd_ptr].touch_width;
    assign o_out.velocity_x  = r_queue[r_rd_ptr].velocity_x;
    assign o_out.velocity_y  = r_queue[r_rd_ptr].velocity_y;
    assign o_out.hold_count  = r_queue[r_rd_ptr].hold_count;
    assign o_out.num_touches = r_queue[r_rd_ptr].num_touches;
    assign o_out.last_of_run = r_queue[r_rd_ptr].last_of_run;

endmodule

`default_nettype wire

// ===== tb/touch_frame_tracker_tb.sv =====
// Testbench for touch_frame_tracker: byte stream in, touch and status results out.
// Needs tft_pkg, tft_if.sv and the tracker RTL; checks every result against
// an in-bench tracker model, or against the directed table for typed rows.
`timescale 1ns / 1ps

module touch_frame_tracker_tb;
    import tft_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASES          = 6;
    localparam int BYTES_PER_PHASE = 200;
    localparam int FLOOD_BYTES     = 30;
    localparam int DIR_ROWS        = 26;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic [2:0] kind;
        logic [2:0] count;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_MOSTLY
    } t_rx_mode;

    // Typed rows carry their one result; the others go through the tracker model.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b1, KIND_ERROR, 3'd0},    // stray byte, low extreme
        '{8'hFF, 1'b1, KIND_ERROR, 3'd0},    // stray byte, high extreme
        '{8'hEE, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},    // empty frame
        '{8'hEE, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h02, 1'b0, KIND_TOUCH, 3'd0},
        '{8'hF0, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},    // short frame, no subtype
        '{8'hEE, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h07, 1'b0, KIND_TOUCH, 3'd0},
        '{8'hEF, 1'b0, KIND_TOUCH, 3'd0},    // enable header under the mask
        '{8'hEE, 1'b0, KIND_TOUCH, 3'd0},    // marker inside the payload
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},
        '{8'hE5, 1'b1, KIND_ENABLE, 3'd0},
        '{8'hEE, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h07, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h10, 1'b0, KIND_TOUCH, 3'd0},
        '{8'hFF, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},
        '{8'h00, 1'b0, KIND_TOUCH, 3'd0},
        '{8'hE0, 1'b1, KIND_SYNC, 3'd0}      // touch frame ending before its count byte
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    tft_byte_if   byte_bus ();
    tft_result_if result_bus ();

    touch_frame_tracker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (byte_bus),
        .o_out       (result_bus)
    );

    // Tracker model state
    t_phase      p_phase;
    logic [7:0]  p_len;
    logic [7:0]  p_pos;
    logic [7:0]  p_hi;
    logic [4:0]  p_hdr;
    logic [4:0]  p_sub;
    int unsigned p_frame_cnt;
    int unsigned p_prev_cnt;
    t_slot       p_slot [MAX_SLOTS];
    logic [15:0] p_x_offset;

    t_result     byte_results [$];
    t_result     pending_results [$];
    logic [7:0]  frame_buf [$];
    logic [7:0]  recent_ids [MAX_SLOTS];

    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    bit          hold_off_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void reset_tracker();
        int i;
        p_phase     = PH_MARK;
        p_len       = '0;
        p_pos       = '0;
        p_hi        = '0;
        p_hdr       = '0;
        p_sub       = '0;
        p_frame_cnt = 0;
        p_prev_cnt  = 0;
        p_x_offset  = '0;
        for (i = 0; i < MAX_SLOTS; i++) begin
            p_slot[i]     = '0;
            recent_ids[i] = 8'($urandom);
        end
    endfunction

    function automatic t_result make_result(logic [2:0] kind, int unsigned s,
                                            int unsigned cnt);
        t_result r;
        r = '0;
        r.kind = kind;
        if (kind == KIND_TOUCH) begin
            r.slot        = s[2:0];
            r.touch_id    = p_slot[s].id;
            r.tip         = (p_slot[s].event_code != EVENT_UP);
            r.pos_x       = p_slot[s].x;
            r.pos_y       = p_slot[s].y;
            r.touch_width = p_slot[s].width;
            r.velocity_x  = p_slot[s].vel_x;
            r.velocity_y  = p_slot[s].vel_y;
            r.hold_count  = p_slot[s].hold;
        end
        r.num_touches = cnt[2:0];
        return r;
    endfunction

    // (7 * old + step) / 8, truncated toward zero
    function automatic logic signed [16:0] smoothed(logic signed [16:0] old, int step);
        int acc;
        acc = 7 * int'(old) + step;
        return 17'(acc / 8);
    endfunction

    function automatic void track_record(int unsigned k, logic [3:0] off, logic [7:0] b);
        int unsigned j;
        int          v;
        int          nv;
        v = int'({p_hi, b});
        case (off)
            OFF_ID: begin
                // take over the last later slot that carries this id
                if (b != p_slot[k].id) begin
                    for (j = k + 1; j < p_prev_cnt && j < MAX_SLOTS; j++) begin
                        if (p_slot[j].id == b)
                            p_slot[k] = p_slot[j];
                    end
                end
                p_slot[k].id = b;
            end
            OFF_EVENT: p_slot[k].event_code = b;
            OFF_X_HI, OFF_Y_HI, OFF_W_HI: p_hi = b;
            OFF_X_LO: begin
                nv = (v > int'(p_x_offset)) ? v - int'(p_x_offset) : 0;
                p_slot[k].vel_x = smoothed(p_slot[k].vel_x, nv - int'(p_slot[k].x));
                p_slot[k].x     = nv[15:0];
            end
            OFF_Y_LO: begin
                p_slot[k].vel_y = smoothed(p_slot[k].vel_y, v - int'(p_slot[k].y));
                p_slot[k].y     = v[15:0];
            end
            OFF_W_LO: begin
                p_slot[k].width = 16'((7 * int'(p_slot[k].width) + v) / 8);
                if (p_slot[k].event_code == EVENT_DOWN) begin
                    p_slot[k].hold  = 8'd1;
                    p_slot[k].vel_x = '0;
                    p_slot[k].vel_y = '0;
                end else if (p_slot[k].hold < HOLD_MAX) begin
                    p_slot[k].hold = p_slot[k].hold + 8'd1;
                end
                byte_results.push_back(make_result(KIND_TOUCH, k, 0));
            end
            default: ;
        endcase
    endfunction

    // Advance the tracker model by one byte; results land in byte_results.
    function automatic void parse_and_track(logic [7:0] b);
        int unsigned pos;
        int unsigned cnt;
        int unsigned k;
        logic [3:0]  off;
        bit          touch_frame;
        byte_results.delete();
        case (p_phase)
            PH_MARK: begin
                if (b == FRAME_MARKER)
                    p_phase = PH_LEN;
                else
                    byte_results.push_back(make_result(KIND_ERROR, 0, 0));
            end
            PH_LEN: begin
                if (b == 8'd0) begin
                    p_phase = PH_MARK;
                end else begin
                    p_len       = b;
                    p_pos       = '0;
                    p_hdr       = '0;
                    p_sub       = '0;
                    p_frame_cnt = 0;
                    p_phase     = PH_BODY;
                end
            end
            default: begin
                pos = p_pos;
                if (pos == POS_HEADER)
                    p_hdr = 5'(b & CODE_MASK);
                else if (pos == POS_SUBTYPE)
                    p_sub = 5'(b & CODE_MASK);
                touch_frame = (p_hdr == HDR_NOTIFY) && (p_sub == SUB_TOUCH)
                              && (pos >= POS_SUBTYPE);
                if (touch_frame && pos == POS_COUNT) begin
                    cnt = b / RECORD_LEN;
                    p_frame_cnt = (cnt > MAX_SLOTS) ? MAX_SLOTS : cnt;
                end
                if (touch_frame && pos >= POS_RECORDS) begin
                    k   = (pos - POS_RECORDS) / RECORD_LEN;
                    off = 4'((pos - POS_RECORDS) % RECORD_LEN);
                    if (k < p_frame_cnt)
                        track_record(k, off, b);
                end
                p_pos = 8'(pos + 1);
                if (pos + 1 >= p_len) begin
                    p_phase = PH_MARK;
                    if (p_len >= MIN_LENGTH) begin
                        if (p_hdr == HDR_NOTIFY && p_sub == SUB_TOUCH) begin
                            byte_results.push_back(make_result(KIND_SYNC, 0, p_frame_cnt));
                            p_prev_cnt = p_frame_cnt;
                        end else if (p_hdr == HDR_NOTIFY && p_sub == SUB_BOOT) begin
                            byte_results.push_back(make_result(KIND_BOOT, 0, 0));
                        end else if (p_hdr == HDR_ENABLE && p_sub == SUB_ENABLE) begin
                            byte_results.push_back(make_result(KIND_ENABLE, 0, 0));
                        end
                    end
                end
            end
        endcase
        if (byte_results.size() > 0)
            byte_results[$].last_of_run = 1'b1;
    endfunction

    // Offer one byte in bursts with random gaps; hold valid across back-to-back bytes.
    task automatic push_byte(input logic [7:0] b, input bit predicted);
        int i;
        if (burst_left == 0) begin
            byte_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= b;
        @(posedge i_clk);
        while (!byte_bus.ready) @(posedge i_clk);
        burst_left--;
        parse_and_track(b);
        if (predicted) begin
            for (i = 0; i < byte_results.size(); i++)
                pending_results.push_back(byte_results[i]);
        end
    endtask

    // Stop sending and wait for every outstanding result, then let the pipe settle.
    task automatic drain();
        byte_bus.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_x_offset(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        p_x_offset = value;
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == FRAME_MARKER);
        return b;
    endfunction

    // Marker, length and random payload with the header and subtype stamped in.
    function automatic void queue_frame(logic [4:0] hdr, logic [4:0] sub, int len);
        int i;
        frame_buf.delete();
        frame_buf.push_back(FRAME_MARKER);
        frame_buf.push_back(8'(len));
        for (i = 0; i < len; i++)
            frame_buf.push_back(8'($urandom));
        if (len > POS_HEADER)
            frame_buf[2 + POS_HEADER] = {frame_buf[2 + POS_HEADER][7:5], hdr};
        if (len > POS_SUBTYPE)
            frame_buf[2 + POS_SUBTYPE] = {frame_buf[2 + POS_SUBTYPE][7:5], sub};
    endfunction

    // Touch notification; mostly complete, now and then cut short or padded.
    function automatic void queue_touch_frame();
        int         n;
        int         used;
        int         full;
        int         len;
        int         k;
        int         i;
        logic [7:0] cnt_byte;
        logic [7:0] id;
        logic [15:0] w;
        logic [7:0] body [$];
        n        = $urandom_range(1, MAX_SLOTS);
        cnt_byte = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                               : 8'(n * 11 + $urandom_range(0, 10));
        used = cnt_byte / RECORD_LEN;
        if (used > MAX_SLOTS)
            used = MAX_SLOTS;
        full = POS_RECORDS + RECORD_LEN * used;
        case ($urandom_range(0, 9))
            0: len = $urandom_range(8, full);
            1: len = full + $urandom_range(1, 6);
            default: len = full;
        endcase
        body.push_back(cnt_byte);
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        for (k = 0; k < used; k++) begin
            // reuse recent ids so records hop between slots
            id = ($urandom_range(0, 3) != 0) ? recent_ids[$urandom_range(0, MAX_SLOTS - 1)]
                                             : 8'($urandom);
            recent_ids[k] = id;
            body.push_back(id);
            body.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 3)));
            repeat (3) begin
                w = rand_word();
                body.push_back(w[15:8]);
                body.push_back(w[7:0]);
            end
            repeat (3) body.push_back(8'($urandom));
        end
        queue_frame(HDR_NOTIFY, SUB_TOUCH, len);
        for (i = 0; i < body.size() && POS_COUNT + i < len; i++)
            frame_buf[2 + POS_COUNT + i] = body[i];
    endfunction

    task automatic report_mismatch(input string what, input logic [16:0] want,
                                   input logic [16:0] seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t: %s: expected %0h, got %0h", $realtime, what, want, seen);
    endtask

    task automatic check_field(input string what, input logic [16:0] want,
                               input logic [16:0] seen);
        if (want !== seen)
            report_mismatch(what, want, seen);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected, kind", '0, result_bus.kind);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, result_bus.kind);
                check_field("slot", want.slot, result_bus.slot);
                check_field("touch_id", want.touch_id, result_bus.touch_id);
                check_field("tip", want.tip, result_bus.tip);
                check_field("pos_x", want.pos_x, result_bus.pos_x);
                check_field("pos_y", want.pos_y, result_bus.pos_y);
                check_field("touch_width", want.touch_width, result_bus.touch_width);
                check_field("velocity_x", want.velocity_x, result_bus.velocity_x);
                check_field("velocity_y", want.velocity_y, result_bus.velocity_y);
                check_field("hold_count", want.hold_count, result_bus.hold_count);
                check_field("num_touches", want.num_touches, result_bus.num_touches);
                check_field("last_of_run", want.last_of_run, result_bus.last_of_run);
            end
        end
    end

    // Receiver: switch stall pattern now and then; hold off on request.
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       hold_left;
        int       rx_tick;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        rx_tick   = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES - 1;
                result_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:         result_bus.ready <= 1'b1;
                    RX_COIN:         result_bus.ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: result_bus.ready <= (rx_tick % 4 == 0);
                    default:         result_bus.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: give up when nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((byte_bus.valid && byte_bus.ready) || (result_bus.valid && result_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_result typed_res;
        int      i;
        int      phase;
        int      phase_bytes;
        int      sel;
        byte_bus.valid     <= 1'b0;
        byte_bus.data_byte <= 8'd0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= 16'd0;
        i_rst_n            <= 1'b0;
        reset_tracker();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            push_byte(DIR_TABLE[i].data, !DIR_TABLE[i].typed);
            if (DIR_TABLE[i].typed) begin
                typed_res             = '0;
                typed_res.kind        = DIR_TABLE[i].kind;
                typed_res.num_touches = DIR_TABLE[i].count;
                typed_res.last_of_run = 1'b1;
                pending_results.push_back(typed_res);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: write_x_offset(16'hFFFF);
                1: write_x_offset(16'h0000);
                2: write_x_offset(16'($urandom));
                3: write_x_offset(16'($urandom_range(1, 16'h0400)));
                4: write_x_offset(16'h8000);
                default: write_x_offset(16'($urandom));
            endcase
            if (phase == 1) begin
                // stall the receiver and flood errors so the result queue backs up
                hold_off_req = 1'b1;
                repeat (FLOOD_BYTES) push_byte(noise_byte(), 1'b1);
            end
            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE) begin
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    queue_touch_frame();
                end else if (sel < 63) begin
                    queue_frame(HDR_NOTIFY, SUB_BOOT, $urandom_range(7, 12));
                end else if (sel < 71) begin
                    queue_frame(HDR_ENABLE, SUB_ENABLE, $urandom_range(7, 12));
                end else if (sel < 80) begin
                    queue_frame(5'($urandom), 5'($urandom), $urandom_range(1, 20));
                end else if (sel < 90) begin
                    // empty, short, or missing its count byte
                    queue_frame(HDR_NOTIFY, SUB_TOUCH, $urandom_range(0, 7));
                end else begin
                    frame_buf.delete();
                    repeat ($urandom_range(1, 4)) frame_buf.push_back(noise_byte());
                end
                foreach (frame_buf[j])
                    push_byte(frame_buf[j], 1'b1);
                phase_bytes += frame_buf.size();
            end
        end

        drain();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
